// ===== hdl/bsts_pkg.sv =====
package bsts_pkg;

  typedef enum logic [4:0] {
    ST_START      = 5'd0,
    ST_DOTFIRST   = 5'd1,
    ST_IDENT      = 5'd2,
    ST_BLANK      = 5'd3,
    ST_QUOTE      = 5'd9,
    ST_QUOTEESC   = 5'd10,
    ST_VERBMARK   = 5'd11,
    ST_VERBATIM   = 5'd12,
    ST_BARE       = 5'd13,
    ST_ERROR      = 5'd14,
    ST_BLANKAFTER = 5'd15,
    ST_NUMBER     = 5'd16,
    ST_LOWER      = 5'd17,
    ST_SINGLE     = 5'd18
  } scan_state_t;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_AMP    = 8'd38;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_0      = 8'd48;
  localparam logic [7:0] CH_9      = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_UA     = 8'd65;
  localparam logic [7:0] CH_UZ     = 8'd90;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_UNDER  = 8'd95;
  localparam logic [7:0] CH_LA     = 8'd97;
  localparam logic [7:0] CH_LZ     = 8'd122;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  // Outcome of one transition: where the machine goes and whether the
  // character is advanced over.
  typedef struct packed {
    scan_state_t st;
    logic        adv;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return c >= CH_LA && c <= CH_LZ;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_lower(c) || (c >= CH_UA && c <= CH_UZ) || is_digit(c) ||
           c == CH_UNDER || c == CH_DOT;
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_AMP ||
           c == CH_SEMI || c == CH_COMMA;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_BSLASH;
  endfunction

endpackage

// ===== hdl/bsts_if.sv =====
interface bsts_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;
  logic       start_scan;
  logic       bare_wanted;
  logic       sentinel_wanted;

  modport source (output valid, op, ch, start_scan, bare_wanted, sentinel_wanted,
                  input ready);
  modport sink (input valid, op, ch, start_scan, bare_wanted, sentinel_wanted,
                output ready);
endinterface

interface bsts_out_if;
  logic valid;
  logic ready;
  logic consumed;
  logic skipped;
  logic done_res;
  logic accepted;

  modport source (output valid, consumed, skipped, done_res, accepted, input ready);
  modport sink (input valid, consumed, skipped, done_res, accepted, output ready);
endinterface

// ===== hdl/bsts_step.sv =====
module bsts_step (
  input  bsts_pkg::scan_state_t cur,
  input  logic [7:0]            c,
  input  logic                  nnb,
  output bsts_pkg::step_t       res
);

  bsts_pkg::step_t fs;

  // Start-state decision; state holds on a terminator stop.
  always_comb begin
    fs.st  = cur;
    fs.adv = 1'b1;
    if (bsts_pkg::is_digit(c)) begin
      fs.st = bsts_pkg::ST_NUMBER;
    end else if (bsts_pkg::is_lower(c)) begin
      fs.st = bsts_pkg::ST_LOWER;
    end else if (bsts_pkg::is_word(c) && c != bsts_pkg::CH_DOT) begin
      fs.st = bsts_pkg::ST_IDENT;
    end else if (c == bsts_pkg::CH_DOT) begin
      fs.st = bsts_pkg::ST_DOTFIRST;
    end else if (bsts_pkg::is_blank(c)) begin
      fs.st = bsts_pkg::ST_BLANK;
    end else if (bsts_pkg::is_stop(c)) begin
      fs.adv = 1'b0;
    end else if (c == bsts_pkg::CH_MINUS || c == bsts_pkg::CH_LPAREN) begin
      fs.st  = nnb ? bsts_pkg::ST_SINGLE : bsts_pkg::ST_ERROR;
      fs.adv = nnb;
    end else if (c == bsts_pkg::CH_SLASH && nnb) begin
      fs.st = bsts_pkg::ST_SINGLE;
    end else if (c == bsts_pkg::CH_STAR || c == bsts_pkg::CH_SLASH ||
                 c == bsts_pkg::CH_PLUS) begin
      fs.st  = bsts_pkg::ST_ERROR;
      fs.adv = 1'b0;
    end else if (c == bsts_pkg::CH_DQUOTE) begin
      fs.st = bsts_pkg::ST_QUOTE;
    end else if (c == bsts_pkg::CH_AT) begin
      fs.st = bsts_pkg::ST_VERBMARK;
    end else begin
      fs.st = bsts_pkg::ST_BARE;
    end
  end

  always_comb begin
    res.st  = cur;
    res.adv = 1'b1;
    case (cur)
      bsts_pkg::ST_START: res = fs;
      bsts_pkg::ST_DOTFIRST: begin
        if (bsts_pkg::is_digit(c)) begin
          res.st = bsts_pkg::ST_NUMBER;
        end else if (bsts_pkg::is_word(c) && c != bsts_pkg::CH_DOT) begin
          res.st = bsts_pkg::ST_IDENT;
        end else if (c == bsts_pkg::CH_DOT) begin
          res.st = bsts_pkg::ST_BARE;
        end else if (bsts_pkg::is_stop(c)) begin
          res.st  = bsts_pkg::ST_BARE;
          res.adv = 1'b0;
        end else begin
          res.st  = bsts_pkg::ST_ERROR;
          res.adv = 1'b0;
        end
      end
      bsts_pkg::ST_LOWER: begin
        if (bsts_pkg::is_lower(c)) begin
          res.st = cur;
        end else if (c == bsts_pkg::CH_LPAREN) begin
          res.st  = bsts_pkg::ST_ERROR;
          res.adv = 1'b0;
        end else if (bsts_pkg::is_word(c)) begin
          res.st = bsts_pkg::ST_IDENT;
        end else begin
          res.st  = bsts_pkg::ST_ERROR;
          res.adv = 1'b0;
        end
      end
      bsts_pkg::ST_IDENT: begin
        if (bsts_pkg::is_word(c)) begin
          res.st = cur;
        end else if (c == bsts_pkg::CH_LPAREN) begin
          res.st = bsts_pkg::ST_BARE;
        end else if (bsts_pkg::is_stop(c)) begin
          res.adv = 1'b0;
        end else if (c == bsts_pkg::CH_SLASH || c == bsts_pkg::CH_MINUS) begin
          res.st = bsts_pkg::ST_BARE;
        end else if (bsts_pkg::is_blank(c)) begin
          res.st = bsts_pkg::ST_BLANKAFTER;
        end else begin
          res = fs;
        end
      end
      bsts_pkg::ST_NUMBER: begin
        if (bsts_pkg::is_digit(c) || c == bsts_pkg::CH_DOT) begin
          res.st = cur;
        end else if (bsts_pkg::is_word(c)) begin
          res.st = bsts_pkg::ST_IDENT;
        end else if (bsts_pkg::is_blank(c) || bsts_pkg::is_stop(c)) begin
          res.adv = 1'b0;
        end else begin
          res.st = bsts_pkg::ST_BARE;
        end
      end
      bsts_pkg::ST_BLANKAFTER: begin
        if (bsts_pkg::is_blank(c)) begin
          res.st = cur;
        end else if (bsts_pkg::is_stop(c)) begin
          res.adv = 1'b0;
        end else begin
          res.st = bsts_pkg::ST_BARE;
        end
      end
      bsts_pkg::ST_BLANK: begin
        if (bsts_pkg::is_blank(c)) begin
          res.st = cur;
        end else if (bsts_pkg::is_stop(c)) begin
          res.st  = bsts_pkg::ST_ERROR;
          res.adv = 1'b0;
        end else begin
          res = fs;
        end
      end
      bsts_pkg::ST_QUOTE: begin
        if (c == bsts_pkg::CH_DQUOTE) begin
          res.adv = 1'b0;
        end else if (c == bsts_pkg::CH_BSLASH) begin
          res.st = bsts_pkg::ST_QUOTEESC;
        end else if (c == bsts_pkg::CH_LF) begin
          res.st = bsts_pkg::ST_ERROR;
        end
      end
      bsts_pkg::ST_QUOTEESC: begin
        res.st = (c != bsts_pkg::CH_LF) ? bsts_pkg::ST_QUOTE : bsts_pkg::ST_ERROR;
      end
      bsts_pkg::ST_VERBMARK: begin
        if (c == bsts_pkg::CH_DQUOTE) begin
          res.st = bsts_pkg::ST_VERBATIM;
        end else begin
          res.adv = 1'b0;
        end
      end
      bsts_pkg::ST_VERBATIM: begin
        if (c == bsts_pkg::CH_DQUOTE) begin
          res.st = bsts_pkg::ST_VERBMARK;
        end
      end
      bsts_pkg::ST_SINGLE: begin
        if (!bsts_pkg::is_blank(c)) begin
          res.st = bsts_pkg::ST_ERROR;
        end
        res.adv = 1'b0;
      end
      bsts_pkg::ST_BARE: res.adv = !bsts_pkg::is_stop(c);
      default: begin
        res.st  = bsts_pkg::ST_ERROR;
        res.adv = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/bare_string_token_scanner.sv =====
// Bare-string token scanner.
// chars (sink): one request per character, or an end-of-input marker (op = 1).
//   A request with start_scan = 1 opens a new scan and is itself the first
//   character; bare_wanted and sentinel_wanted are sampled on that request.
// verdict (source): exactly one result per request, in order: consumed,
//   skipped (whitespace advanced over), done_res (scan ended here) and
//   accepted (with done_res: a bare-string token ends after the last
//   consumed character).
// Output: the result is loaded into the output register in the cycle after
//   the request is taken. Throughput: one request per cycle while verdict is
//   not stalled; the scan state is updated by a single transition in the
//   accepting cycle, so a new character may follow on every unstalled clock.
// Stall: chars.ready stays high while the output register is empty or being
//   drained; when verdict is stalled with a result held, chars.ready drops
//   and the held result stays stable until taken.
// Reset (rst, synchronous): the output register empties, the machine goes to
//   the start state and the scan is marked over, so non-start requests are
//   answered with all-zero results until a start request arrives.
module bare_string_token_scanner (
  input logic            clk,
  input logic            rst,
  bsts_in_if.sink        chars,
  bsts_out_if.source     verdict
);

  bsts_pkg::scan_state_t scan_state, scan_state_next;
  logic                  has_content, has_content_next;
  logic                  nothing_nonblank_yet, nothing_nonblank_yet_next;
  logic                  scan_over, scan_over_next;

  logic out_valid;
  logic consumed, consumed_next;
  logic skipped, skipped_next;
  logic done_res, done_res_next;
  logic accepted, accepted_next;

  logic take;

  // State as seen by this request after a possible scan restart.
  bsts_pkg::scan_state_t cur_state;
  logic                  cur_hc, cur_nnb, cur_over;
  bsts_pkg::step_t       step;

  // Take a request whenever the result slot is free or is being drained.
  assign chars.ready = !out_valid || verdict.ready;
  assign take        = chars.valid && chars.ready;

  always_comb begin
    if (chars.start_scan) begin
      cur_state = bsts_pkg::ST_START;
      cur_hc    = 1'b0;
      cur_nnb   = 1'b1;
      cur_over  = 1'b0;
    end else begin
      cur_state = scan_state;
      cur_hc    = has_content;
      cur_nnb   = nothing_nonblank_yet;
      cur_over  = scan_over;
    end
  end

  bsts_step u_step (
    .cur (cur_state),
    .c   (chars.ch),
    .nnb (cur_nnb),
    .res (step)
  );

  always_comb begin
    scan_state_next           = cur_state;
    has_content_next          = cur_hc;
    nothing_nonblank_yet_next = cur_nnb;
    scan_over_next            = cur_over;
    consumed_next             = 1'b0;
    skipped_next              = 1'b0;
    done_res_next             = 1'b0;
    accepted_next             = 1'b0;
    if (chars.start_scan && (!chars.bare_wanted || chars.sentinel_wanted)) begin
      // Refused scan: end at once with nothing consumed.
      scan_over_next = 1'b1;
      done_res_next  = 1'b1;
    end else if (cur_over) begin
      // Late request after the scan ended: drop it, answer with zeros.
    end else if (!chars.op && step.adv) begin
      // Advance over the character.
      scan_state_next  = step.st;
      has_content_next = 1'b1;
      if (step.st != bsts_pkg::ST_BLANK) begin
        nothing_nonblank_yet_next = 1'b0;
      end
      consumed_next = 1'b1;
      skipped_next  = (step.st == bsts_pkg::ST_BLANK);
    end else begin
      // Stop: on end of input the state holds, otherwise take the stop state.
      if (!chars.op) begin
        scan_state_next = step.st;
      end
      scan_over_next = 1'b1;
      done_res_next  = 1'b1;
      accepted_next  = cur_hc && (scan_state_next == bsts_pkg::ST_BARE ||
                                  scan_state_next == bsts_pkg::ST_SINGLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state           <= bsts_pkg::ST_START;
      has_content          <= 1'b0;
      nothing_nonblank_yet <= 1'b1;
      scan_over            <= 1'b1;
    end else if (take) begin
      scan_state           <= scan_state_next;
      has_content          <= has_content_next;
      nothing_nonblank_yet <= nothing_nonblank_yet_next;
      scan_over            <= scan_over_next;
    end
  end

  // Output register: load on take, empty when drained with nothing new.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      consumed <= consumed_next;
      skipped  <= skipped_next;
      done_res <= done_res_next;
      accepted <= accepted_next;
    end
  end

  assign verdict.valid    = out_valid;
  assign verdict.consumed = consumed;
  assign verdict.skipped  = skipped;
  assign verdict.done_res = done_res;
  assign verdict.accepted = accepted;

endmodule

// ===== hdl/bsts_check.sv =====
module bsts_check (
  input logic         clk,
  input logic         rst,
  bsts_in_if.sink     chars,
  bsts_out_if.source  verdict
);

  // A held result stays put while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict.valid && !verdict.ready |=>
      verdict.valid && $stable(verdict.consumed) && $stable(verdict.done_res) &&
      $stable(verdict.accepted) && $stable(verdict.skipped))
    else $error("result changed while stalled");

  // Every taken request yields a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.ready |=> verdict.valid)
    else $error("missing result after request");

  // Skipped only with consumed; accepted only with done.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (!verdict.skipped || verdict.consumed) &&
                      (!verdict.accepted || verdict.done_res))
    else $error("inconsistent result flags");

  // A character is never both advanced over and the end of the scan.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> !(verdict.consumed && verdict.done_res))
    else $error("consumed and done together");

  // A start with bare_wanted low is refused: it ends the scan without accepting.
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.ready && chars.start_scan && !chars.bare_wanted |=>
      verdict.done_res && !verdict.accepted && !verdict.consumed)
    else $error("refused scan not ended");

endmodule

bind bare_string_token_scanner bsts_check u_bsts_check (
  .clk     (clk),
  .rst     (rst),
  .chars   (chars),
  .verdict (verdict)
);
